>>> hdl/rcu_gp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rcu_gp_pkg;

   localparam int NUM_CPUS     = 8;
   localparam int BATCH_BITS   = 16;
   localparam int COUNT_BITS   = 16;
   localparam int CPU_IDX_BITS = $clog2(NUM_CPUS);

   localparam logic [BATCH_BITS-1:0] RESET_BATCH = BATCH_BITS'(-300);

   typedef logic [BATCH_BITS-1:0] batch_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [NUM_CPUS-1:0]   mask_type;

   typedef enum logic [2:0] {
      KIND_ENQUEUE    = 3'd0,
      KIND_QUIET      = 3'd1,
      KIND_PROCESS    = 3'd2,
      KIND_PENDING    = 3'd3,
      KIND_IDLE_ENTER = 3'd4,
      KIND_IDLE_LEAVE = 3'd5,
      KIND_OFFLINE    = 3'd6
   } kind_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] cpu_index;
      logic [2:0] target_cpu;
   } req_type;

   typedef struct packed {
      logic [15:0] released_count;
      logic        work_pending;
      logic        has_work;
      logic [15:0] current_number;
      logic [15:0] completed_number;
      logic [7:0]  waiting_cpus;
      logic        count_overflow;
   } rsp_type;

   typedef struct packed {
      batch_type                   global_current;
      batch_type                   global_completed;
      logic                        next_batch_queued;
      mask_type                    waiting_mask;
      mask_type                    active_mask;
      logic [NUM_CPUS-1:0][BATCH_BITS-1:0] quiet_batch;
      mask_type                    quiet_passed;
      mask_type                    awaiting_quiet;
      mask_type                    cpu_idle;
      logic [NUM_CPUS-1:0][BATCH_BITS-1:0] assigned_batch;
      logic [NUM_CPUS-1:0][COUNT_BITS-1:0] new_count;
      logic [NUM_CPUS-1:0][COUNT_BITS-1:0] waiting_count;
   } state_type;

   // wrapped compare: a is at or past b
   function automatic logic batch_ge(batch_type a, batch_type b);
      batch_type diff;
      diff = a - b;
      return ~diff[BATCH_BITS-1];
   endfunction

   function automatic state_type reset_state();
      state_type s;
      s = '0;
      s.global_current   = RESET_BATCH;
      s.global_completed = RESET_BATCH;
      s.cpu_idle         = '1;
      return s;
   endfunction

endpackage

`default_nettype wire

>>> hdl/rcu_gp_step.sv
`timescale 1ns / 1ps
`default_nettype none

module rcu_gp_step (
   input  wire rcu_gp_pkg::state_type state_cur,
   input  wire rcu_gp_pkg::req_type   req,
   output rcu_gp_pkg::state_type state_next,
   output rcu_gp_pkg::rsp_type   rsp
);
   import rcu_gp_pkg::*;

   function automatic state_type begin_batch(state_type s);
      state_type n;
      n = s;
      if (n.next_batch_queued && n.global_completed == n.global_current) begin
         n.next_batch_queued = 1'b0;
         n.global_current    = n.global_current + 1'b1;
         n.waiting_mask      = n.active_mask;
      end
      return n;
   endfunction

   function automatic state_type mark_quiet(state_type s, logic [CPU_IDX_BITS-1:0] c);
      state_type n;
      n = s;
      n.waiting_mask[c] = 1'b0;
      if (n.waiting_mask == '0) begin
         n.global_completed = n.global_current;
         n = begin_batch(n);
      end
      return n;
   endfunction

   function automatic state_type check_quiet(state_type s, logic [CPU_IDX_BITS-1:0] c);
      state_type n;
      n = s;
      if (n.quiet_batch[c] != n.global_current) begin
         n.awaiting_quiet[c] = 1'b1;
         n.quiet_passed[c]   = 1'b0;
         n.quiet_batch[c]    = n.global_current;
      end else if (n.awaiting_quiet[c] && n.quiet_passed[c]) begin
         n.awaiting_quiet[c] = 1'b0;
         n = mark_quiet(n, c);
      end
      return n;
   endfunction

   function automatic logic releasable(state_type s, logic [CPU_IDX_BITS-1:0] c);
      return (s.waiting_count[c] != '0) &&
             batch_ge(s.global_completed, s.assigned_batch[c]);
   endfunction

   function automatic logic is_pending(state_type s, logic [CPU_IDX_BITS-1:0] c);
      return releasable(s, c) ||
             (s.waiting_count[c] == '0 && s.new_count[c] != '0) ||
             (s.quiet_batch[c] != s.global_current) || s.awaiting_quiet[c];
   endfunction

   function automatic state_type process(state_type s, logic [CPU_IDX_BITS-1:0] c);
      state_type n;
      n = s;
      if (releasable(n, c)) begin
         n.waiting_count[c] = '0;
      end
      if (n.new_count[c] != '0 && n.waiting_count[c] == '0) begin
         n.waiting_count[c]  = n.new_count[c];
         n.new_count[c]      = '0;
         n.assigned_batch[c] = n.global_current + 1'b1;
         if (!n.next_batch_queued) begin
            n.next_batch_queued = 1'b1;
            n = begin_batch(n);
         end
      end
      n = check_quiet(n, c);
      return n;
   endfunction

   // saturating add, overflow flag on top
   function automatic logic [COUNT_BITS:0] cnt_add(count_type a, count_type b);
      logic [COUNT_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum[COUNT_BITS]) begin
         return {1'b1, {COUNT_BITS{1'b1}}};
      end
      return sum;
   endfunction

   state_type                 n;
   count_type                 rel;
   logic                      ovf;
   logic                      wp;
   logic                      hw;
   logic                      c_ok;
   logic                      t_ok;
   logic [CPU_IDX_BITS-1:0]   c;
   logic [CPU_IDX_BITS-1:0]   t;
   logic [COUNT_BITS:0]       sum_a;
   logic [COUNT_BITS:0]       sum_b;

   always_comb begin
      n     = state_cur;
      rel   = '0;
      ovf   = 1'b0;
      wp    = 1'b0;
      hw    = 1'b0;
      sum_a = '0;
      sum_b = '0;
      c     = req.cpu_index[CPU_IDX_BITS-1:0];
      t     = req.target_cpu[CPU_IDX_BITS-1:0];
      c_ok  = 32'(req.cpu_index) < NUM_CPUS;
      t_ok  = 32'(req.target_cpu) < NUM_CPUS;
      if (c_ok) begin
         unique case (req.kind)
            KIND_ENQUEUE: begin
               sum_a          = cnt_add(n.new_count[c], COUNT_BITS'(1));
               ovf            = sum_a[COUNT_BITS];
               n.new_count[c] = sum_a[COUNT_BITS-1:0];
            end
            KIND_QUIET: begin
               n.quiet_passed[c] = 1'b1;
            end
            KIND_PROCESS: begin
               if (releasable(n, c)) begin
                  rel = n.waiting_count[c];
               end
               n = process(n, c);
            end
            KIND_PENDING: begin
               if (is_pending(n, c)) begin
                  n.quiet_passed[c] = 1'b1;
                  if (releasable(n, c)) begin
                     rel = n.waiting_count[c];
                  end
                  n = process(n, c);
               end
            end
            KIND_IDLE_ENTER: begin
               if (!n.cpu_idle[c]) begin
                  n.cpu_idle[c]    = 1'b1;
                  n.active_mask[c] = 1'b0;
                  if (n.quiet_batch[c] != n.global_current || n.awaiting_quiet[c]) begin
                     n.quiet_batch[c]    = n.global_current;
                     n.awaiting_quiet[c] = 1'b0;
                     n = mark_quiet(n, c);
                  end
               end
            end
            KIND_IDLE_LEAVE: begin
               if (n.cpu_idle[c]) begin
                  n.cpu_idle[c]    = 1'b0;
                  n.active_mask[c] = 1'b1;
                  n.quiet_batch[c] = n.global_current;
               end
            end
            KIND_OFFLINE: begin
               if (t != c && t_ok) begin
                  if (n.global_current != n.global_completed) begin
                     n = mark_quiet(n, c);
                  end
                  // hand both counts to the target, waiting ones first
                  sum_a = cnt_add(n.new_count[t], n.waiting_count[c]);
                  sum_b = cnt_add(sum_a[COUNT_BITS-1:0], n.new_count[c]);
                  ovf   = sum_a[COUNT_BITS] | sum_b[COUNT_BITS];
                  n.new_count[t]     = sum_b[COUNT_BITS-1:0];
                  n.waiting_count[c] = '0;
                  n.new_count[c]     = '0;
               end
            end
            default: begin
            end
         endcase
         wp = is_pending(n, c);
         hw = (n.waiting_count[c] != '0) || wp;
      end
   end

   assign state_next              = n;
   assign rsp.released_count      = 16'(rel);
   assign rsp.work_pending        = wp;
   assign rsp.has_work            = hw;
   assign rsp.current_number      = 16'(n.global_current);
   assign rsp.completed_number    = 16'(n.global_completed);
   assign rsp.waiting_cpus        = 8'(n.waiting_mask);
   assign rsp.count_overflow      = ovf;

endmodule

`default_nettype wire

>>> hdl/rcu_grace_period_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

// Grace period tracker for classic read-copy-update, counting callbacks per
// processor. Software posts one event word at a time on req_word (kind,
// cpu_index, target_cpu) by raising start for a cycle; the word is taken at
// any edge where start is high and busy is low. busy stays low: a new word
// can be taken at every clock edge.
// Each word is latched into an input register; the step logic then updates
// the global batch numbers, the waiting and active masks and the addressed
// processor's flags and counts combinationally; the state and result
// registers then take them. The result word is on rsp_word for exactly one
// cycle, marked by rsp_valid. One result per event, in order, one per cycle.
// The receiver cannot stall; it must take each result in the cycle it shows.
// released_count tells software how many callbacks it may now invoke.
// Reset (synchronous, active high) puts both batch numbers at -300 modulo
// the batch width, clears masks and counts and marks every processor idle;
// no event is in flight after reset.

module rcu_grace_period_tracker (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  wire rcu_gp_pkg::req_type req_word,
   output logic                 rsp_valid,
   output rcu_gp_pkg::rsp_type  rsp_word
);
   import rcu_gp_pkg::*;

   req_type   req_ff;
   logic      req_valid_ff;
   state_type state_ff;
   state_type state_in;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      rsp_valid_ff;

   rcu_gp_step u_step (
      .state_cur  (state_ff),
      .req        (req_ff),
      .state_next (state_in),
      .rsp        (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= reset_state();
      end else begin
         req_valid_ff <= start;
         rsp_valid_ff <= req_valid_ff;
         // commit state only for a latched word
         if (req_valid_ff) begin
            state_ff <= state_in;
         end
      end
      if (start) begin
         req_ff <= req_word;
      end
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy      = 1'b0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_rsp_follows_word: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff |=> rsp_valid_ff)
      else $error("latched word produced no result");

   a_batch_gap: assert property (@(posedge clock) disable iff (reset)
      (state_ff.global_current == state_ff.global_completed) ||
      (state_ff.global_current == state_ff.global_completed + 1'b1))
      else $error("current batch more than one past completed");

   a_waiting_needs_batch: assert property (@(posedge clock) disable iff (reset)
      (state_ff.waiting_mask != '0) |->
      (state_ff.global_current != state_ff.global_completed))
      else $error("processors waiting with no grace period running");

   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.current_number == 16'(state_ff.global_current) &&
                        rsp_ff.waiting_cpus == 8'(state_ff.waiting_mask)))
      else $error("result word disagrees with committed state");

endmodule

`default_nettype wire

>>> bench/rcu_gp_checker.sv
`timescale 1ns / 1ps

module rcu_gp_checker
   import rcu_gp_pkg::*;
(
   input  wire      clock,
   input  wire      reset,
   input  wire      start,
   input  wire      busy,
   input  req_type  req_word,
   input  wire      rsp_valid,
   input  rsp_type  rsp_word,
   output int       outstanding,
   output int       mismatches,
   output int       checked
);

   // tracker image, advanced once per accepted event word
   batch_type cur_batch;
   batch_type done_batch;
   logic      batch_queued;
   mask_type  owe_mask;
   mask_type  live_mask;
   batch_type seen_batch [NUM_CPUS];
   mask_type  passed_flag;
   mask_type  owe_flag;
   mask_type  idle_flag;
   batch_type held_batch [NUM_CPUS];
   count_type fresh_cnt [NUM_CPUS];
   count_type held_cnt [NUM_CPUS];
   logic      saturated;

   rsp_type   rsp_due [$];

   task automatic clear_tracker();
      cur_batch    = RESET_BATCH;
      done_batch   = RESET_BATCH;
      batch_queued = 1'b0;
      owe_mask     = '0;
      live_mask    = '0;
      passed_flag  = '0;
      owe_flag     = '0;
      idle_flag    = '1;
      for (int i = 0; i < NUM_CPUS; i++) begin
         seen_batch[i] = '0;
         held_batch[i] = '0;
         fresh_cnt[i]  = '0;
         held_cnt[i]   = '0;
      end
   endtask

   // a is at or past b in wrapped batch order
   function automatic logic at_or_past(batch_type a, batch_type b);
      batch_type diff;
      diff = a - b;
      return diff < (batch_type'(1) << (BATCH_BITS - 1));
   endfunction

   function automatic count_type sat_add(count_type a, count_type b);
      logic [COUNT_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum[COUNT_BITS]) begin
         saturated = 1'b1;
         return '1;
      end
      return sum[COUNT_BITS-1:0];
   endfunction

   function automatic void open_batch();
      if (batch_queued && done_batch == cur_batch) begin
         batch_queued = 1'b0;
         cur_batch    = cur_batch + 1'b1;
         owe_mask     = live_mask;
      end
   endfunction

   function automatic void retire_cpu(int c);
      owe_mask[c] = 1'b0;
      if (owe_mask == '0) begin
         done_batch = cur_batch;
         open_batch();
      end
   endfunction

   function automatic logic work_due(int c);
      if (held_cnt[c] != 0 && at_or_past(done_batch, held_batch[c]))
         return 1'b1;
      if (held_cnt[c] == 0 && fresh_cnt[c] != 0)
         return 1'b1;
      return seen_batch[c] != cur_batch || owe_flag[c];
   endfunction

   function automatic count_type run_process(int c);
      count_type rel;
      rel = '0;
      if (held_cnt[c] != 0 && at_or_past(done_batch, held_batch[c])) begin
         rel         = held_cnt[c];
         held_cnt[c] = '0;
      end
      if (fresh_cnt[c] != 0 && held_cnt[c] == 0) begin
         held_cnt[c]   = fresh_cnt[c];
         fresh_cnt[c]  = '0;
         held_batch[c] = cur_batch + 1'b1;
         if (!batch_queued) begin
            batch_queued = 1'b1;
            open_batch();
         end
      end
      // first look at a new batch arms the quiescent check
      if (seen_batch[c] != cur_batch) begin
         owe_flag[c]    = 1'b1;
         passed_flag[c] = 1'b0;
         seen_batch[c]  = cur_batch;
      end else if (owe_flag[c] && passed_flag[c]) begin
         owe_flag[c] = 1'b0;
         retire_cpu(c);
      end
      return rel;
   endfunction

   task automatic apply_event(input req_type w, output rsp_type r);
      int        c;
      int        t;
      count_type rel;
      logic      wp;
      logic      hw;
      c         = int'(w.cpu_index);
      t         = int'(w.target_cpu);
      rel       = '0;
      wp        = 1'b0;
      hw        = 1'b0;
      saturated = 1'b0;
      if (c < NUM_CPUS) begin
         case (w.kind)
            KIND_ENQUEUE: fresh_cnt[c] = sat_add(fresh_cnt[c], count_type'(1));
            KIND_QUIET:   passed_flag[c] = 1'b1;
            KIND_PROCESS: rel = run_process(c);
            KIND_PENDING: begin
               if (work_due(c)) begin
                  passed_flag[c] = 1'b1;
                  rel = run_process(c);
               end
            end
            KIND_IDLE_ENTER: begin
               if (!idle_flag[c]) begin
                  idle_flag[c] = 1'b1;
                  live_mask[c] = 1'b0;
                  if (seen_batch[c] != cur_batch || owe_flag[c]) begin
                     seen_batch[c] = cur_batch;
                     owe_flag[c]   = 1'b0;
                     retire_cpu(c);
                  end
               end
            end
            KIND_IDLE_LEAVE: begin
               if (idle_flag[c]) begin
                  idle_flag[c]  = 1'b0;
                  live_mask[c]  = 1'b1;
                  seen_batch[c] = cur_batch;
               end
            end
            KIND_OFFLINE: begin
               if (t != c && t < NUM_CPUS) begin
                  if (cur_batch != done_batch)
                     retire_cpu(c);
                  fresh_cnt[t] = sat_add(fresh_cnt[t], held_cnt[c]);
                  fresh_cnt[t] = sat_add(fresh_cnt[t], fresh_cnt[c]);
                  held_cnt[c]  = '0;
                  fresh_cnt[c] = '0;
               end
            end
            default: ;
         endcase
         wp = work_due(c);
         hw = held_cnt[c] != 0 || wp;
      end
      r.released_count   = 16'(rel);
      r.work_pending     = wp;
      r.has_work         = hw;
      r.current_number   = 16'(cur_batch);
      r.completed_number = 16'(done_batch);
      r.waiting_cpus     = 8'(owe_mask);
      r.count_overflow   = saturated;
   endtask

   task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
         $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type pred;
      if (reset) begin
         clear_tracker();
         rsp_due.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (rsp_due.size() == 0) begin
               $display("[%0t] result word with no event outstanding", $realtime);
               mismatches++;
            end else begin
               want = rsp_due.pop_front();
               checked++;
               report_mismatch("released_count", rsp_word.released_count,
                               want.released_count);
               report_mismatch("work_pending", 16'(rsp_word.work_pending),
                               16'(want.work_pending));
               report_mismatch("has_work", 16'(rsp_word.has_work), 16'(want.has_work));
               report_mismatch("current_number", rsp_word.current_number,
                               want.current_number);
               report_mismatch("completed_number", rsp_word.completed_number,
                               want.completed_number);
               report_mismatch("waiting_cpus", 16'(rsp_word.waiting_cpus),
                               16'(want.waiting_cpus));
               report_mismatch("count_overflow", 16'(rsp_word.count_overflow),
                               16'(want.count_overflow));
            end
         end
         if (start && !busy) begin
            apply_event(req_word, pred);
            rsp_due = {rsp_due, pred};
         end
      end
      outstanding = rsp_due.size();
   end

endmodule

>>> bench/tb_rcu_grace_period_tracker.sv
`timescale 1ns / 1ps

module tb_rcu_grace_period_tracker;
   import rcu_gp_pkg::*;

   localparam logic [2:0] KIND_UNUSED = 3'd7;
   localparam int         LIMIT       = 800000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_word;
   logic    rsp_valid;
   rsp_type rsp_word;

   int outstanding;
   int mismatches;
   int checked;
   int cycles;
   int words_sent;
   int random_sent;
   bit gaps_on;

   rcu_grace_period_tracker dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   rcu_gp_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_word    (rsp_word),
      .outstanding (outstanding),
      .mismatches  (mismatches),
      .checked     (checked)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILURE");
         $finish;
      end
   end

   // hold start low, with junk on the word
   task automatic rest(int n);
      repeat (n) begin
         @(negedge clock);
         start    <= 1'b0;
         req_word <= req_type'($urandom);
      end
   endtask

   task automatic send_word(logic [2:0] kind, logic [2:0] cpu, logic [2:0] tgt);
      if (gaps_on && $urandom_range(0, 7) == 0)
         rest($urandom_range(1, 18));
      @(negedge clock);
      start    <= 1'b1;
      req_word <= '{kind: kind, cpu_index: cpu, target_cpu: tgt};
      @(posedge clock);
      while (busy) @(posedge clock);
      words_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic grace_round();
      logic [2:0] c;
      repeat ($urandom_range(1, 4))
         send_word(KIND_ENQUEUE, 3'($urandom), 3'($urandom));
      repeat ($urandom_range(2, 6)) begin
         c = 3'($urandom);
         send_word(KIND_QUIET, c, 3'($urandom));
         send_word(KIND_PROCESS, c, 3'($urandom));
      end
      repeat ($urandom_range(1, 4))
         send_word(KIND_PENDING, 3'($urandom), 3'($urandom));
   endtask

   initial begin
      logic [2:0] c;
      int         pick;
      int         before_cnt;
      reset    = 1'b1;
      start    = 1'b0;
      req_word = '0;
      gaps_on  = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: fresh state, unused kind, idle transitions, offline cases
      send_word(KIND_PROCESS, 3'd0, 3'd0);
      send_word(KIND_UNUSED, 3'd7, 3'd7);
      send_word(KIND_IDLE_LEAVE, 3'd0, 3'd7);
      send_word(KIND_IDLE_LEAVE, 3'd7, 3'd0);
      send_word(KIND_IDLE_LEAVE, 3'd7, 3'd0);
      send_word(KIND_ENQUEUE, 3'd0, 3'd0);
      send_word(KIND_ENQUEUE, 3'd0, 3'd0);
      send_word(KIND_ENQUEUE, 3'd7, 3'd0);
      send_word(KIND_PROCESS, 3'd0, 3'd0);
      send_word(KIND_PROCESS, 3'd7, 3'd0);
      send_word(KIND_QUIET, 3'd0, 3'd0);
      send_word(KIND_PROCESS, 3'd0, 3'd0);
      send_word(KIND_OFFLINE, 3'd7, 3'd7);
      send_word(KIND_OFFLINE, 3'd7, 3'd3);
      send_word(KIND_PENDING, 3'd0, 3'd0);
      send_word(KIND_PENDING, 3'd0, 3'd0);
      send_word(KIND_PENDING, 3'd3, 3'd0);
      send_word(KIND_PENDING, 3'd3, 3'd0);
      send_word(KIND_IDLE_ENTER, 3'd0, 3'd0);
      send_word(KIND_IDLE_ENTER, 3'd0, 3'd0);
      send_word(KIND_IDLE_ENTER, 3'd7, 3'd0);
      send_word(KIND_ENQUEUE, 3'd5, 3'd2);
      send_word(KIND_PROCESS, 3'd5, 3'd2);
      send_word(KIND_IDLE_LEAVE, 3'd5, 3'd0);
      send_word(KIND_IDLE_ENTER, 3'd5, 3'd0);
      drain();

      // all idle, then gather every count on processor 0 and clear owed bits
      for (int i = 0; i < NUM_CPUS; i++)
         send_word(KIND_IDLE_ENTER, 3'(i), 3'($urandom));
      for (int i = 1; i <= NUM_CPUS; i++)
         send_word(KIND_OFFLINE, 3'(i - 1), 3'(i % NUM_CPUS));
      send_word(KIND_ENQUEUE, 3'd0, 3'd0);

      // each pair opens a batch and closes it by offline; crosses the wrap
      for (int i = 0; i < 310; i++) begin
         send_word(KIND_PENDING, 3'(i % 2), 3'($urandom));
         send_word(KIND_OFFLINE, 3'(i % 2), 3'((i + 1) % 2));
      end
      drain();

      // mixed traffic, mostly complete grace period rounds
      random_sent = 0;
      while (random_sent < 90) begin
         before_cnt = words_sent;
         gaps_on    = random_sent < 60;
         pick       = $urandom_range(0, 9);
         if (pick < 5)
            grace_round();
         else if (pick < 7)
            send_word($urandom_range(0, 1) ? KIND_IDLE_ENTER : KIND_IDLE_LEAVE,
                      3'($urandom), 3'($urandom));
         else if (pick == 7)
            send_word(KIND_OFFLINE, 3'($urandom), 3'($urandom));
         else
            send_word(3'($urandom), 3'($urandom), 3'($urandom));
         random_sent += words_sent - before_cnt;
      end

      drain();
      repeat (10) @(posedge clock);
      $display("Drove %0d event words: directed cases, batch number wrap, random rounds",
               words_sent);
      $display("Compared %0d result words, %0d mismatches, %0d left outstanding",
               checked, mismatches, outstanding);
      if (mismatches == 0 && outstanding == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
